>>> hw/rtl/srec_pkg.sv
// Shared types, codes and helpers for the S3 record emitter.
// No dependencies.
`default_nettype none

package srec_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned AddrW  = 32;

  localparam logic [7:0] CharS      = 8'h53;
  localparam logic [7:0] Char3      = 8'h33;
  localparam logic [7:0] Char7      = 8'h37;
  localparam logic [7:0] CharNl     = 8'h0A;
  localparam logic [7:0] CountBias  = 8'd5;

  typedef enum logic [1:0] {
    OpData    = 2'd0,
    OpSetAddr = 2'd1,
    OpFlush   = 2'd2,
    OpEnd     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PhIdle,
    PhHead,
    PhCount,
    PhAddr,
    PhData,
    PhSum,
    PhEol
  } phase_e;

  // one closed request: optional data record, optional end record
  typedef struct packed {
    logic              data_en;
    logic              end_en;
    logic              bank;
    logic [CountW-1:0] count;
    logic [AddrW-1:0]  rec_addr;
    logic [7:0]        sum;
    logic [AddrW-1:0]  start_addr;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [CountW-1:0] idx;
    logic [7:0]        data;
  } buf_wr_t;

  typedef struct packed {
    logic              bank;
    logic [CountW-1:0] idx;
  } buf_rd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    hex_digit = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

  function automatic logic [15:0] hex_pair(input logic [7:0] b);
    hex_pair = {hex_digit(b[7:4]), hex_digit(b[3:0])};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/srec_if.sv
// Valid/ready channel interfaces for request input and character-pair output.
// No dependencies.
`default_nettype none

interface srec_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  data_byte;
  logic [31:0] address;

  modport source (output valid, opcode, data_byte, address, input ready);
  modport sink   (input valid, opcode, data_byte, address, output ready);
endinterface

interface srec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_pair;
  logic [1:0]  pair_count;
  logic        last;

  modport source (output valid, char_pair, pair_count, last, input ready);
  modport sink   (input valid, char_pair, pair_count, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/srec_fifo.sv
// Short command queue between front and back.
// Depends on srec_pkg.
`default_nettype none

module srec_fifo
  import srec_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  cmd_t push_data_i,
  input  wire  pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/srec_buf.sv
// Two-bank record byte buffer: one write port (front), one registered read (back).
// Depends on srec_pkg.
`default_nettype none

module srec_buf
  import srec_pkg::*;
#(
  parameter int unsigned RECORD_BYTES = 20
) (
  input  wire        clk_i,
  input  buf_wr_t    wr_i,
  input  buf_rd_t    rd_i,
  output logic [7:0] rdata_o
);

  localparam int unsigned Depth = 2 * RECORD_BYTES;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]    mem [Depth];
  logic [AW-1:0] waddr, raddr;

  assign waddr = wr_i.bank ? AW'(RECORD_BYTES) + AW'(wr_i.idx) : AW'(wr_i.idx);
  assign raddr = rd_i.bank ? AW'(RECORD_BYTES) + AW'(rd_i.idx) : AW'(rd_i.idx);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[waddr] <= wr_i.data;
    end
    rdata_o <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/srec_front.sv
// Front end: accepts requests, fills the open record, closes records into commands.
// Depends on srec_pkg and srec_if.
`default_nettype none

module srec_front
  import srec_pkg::*;
#(
  parameter int unsigned RECORD_BYTES = 20
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  srec_in_if.sink     in_i,
  input  wire         fifo_full_i,
  input  wire         data_done_i,
  output logic        push_o,
  output cmd_t        cmd_o,
  output buf_wr_t     wr_o
);

  logic              bank_q, bank_d;
  logic [CountW-1:0] count_q, count_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [7:0]        sum_q, sum_d;
  logic [1:0]        inflight_q, inflight_d;

  logic              accept;
  logic [CountW-1:0] count_inc;
  logic [7:0]        sum_inc;
  logic              held;
  op_e               op;

  assign in_i.ready = !fifo_full_i && (inflight_q != 2'd2);
  assign accept     = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.opcode);
  assign count_inc  = count_q + CountW'(1);
  assign sum_inc    = sum_q + in_i.data_byte;
  assign held       = (count_q != '0);

  always_comb begin
    bank_d  = bank_q;
    count_d = count_q;
    addr_d  = addr_q;
    sum_d   = sum_q;
    push_o  = 1'b0;
    wr_o    = '{en: 1'b0, bank: bank_q, idx: count_q, data: in_i.data_byte};
    cmd_o   = '{data_en: held, end_en: 1'b0, bank: bank_q, count: count_q,
                rec_addr: addr_q, sum: sum_q, start_addr: in_i.address};
    if (accept) begin
      unique case (op)
        OpData: begin
          wr_o.en = 1'b1;
          if (count_inc == CountW'(RECORD_BYTES)) begin
            push_o        = 1'b1;
            cmd_o.data_en = 1'b1;
            cmd_o.count   = count_inc;
            cmd_o.sum     = sum_inc;
            addr_d        = addr_q + AddrW'(RECORD_BYTES);
            count_d       = '0;
            sum_d         = '0;
            bank_d        = ~bank_q;
          end else begin
            count_d = count_inc;
            sum_d   = sum_inc;
          end
        end
        OpSetAddr: begin
          push_o  = held;
          addr_d  = in_i.address;
          count_d = '0;
          sum_d   = '0;
          bank_d  = held ? ~bank_q : bank_q;
        end
        OpFlush: begin
          push_o  = held;
          addr_d  = addr_q + {{(AddrW-CountW){1'b0}}, count_q};
          count_d = '0;
          sum_d   = '0;
          bank_d  = held ? ~bank_q : bank_q;
        end
        OpEnd: begin
          push_o       = 1'b1;
          cmd_o.end_en = 1'b1;
          addr_d       = in_i.address;
          count_d      = '0;
          sum_d        = '0;
          bank_d       = held ? ~bank_q : bank_q;
        end
        default: ;
      endcase
    end
    inflight_d = inflight_q + {1'b0, push_o && cmd_o.data_en} - {1'b0, data_done_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q     <= 1'b0;
      count_q    <= '0;
      addr_q     <= '0;
      sum_q      <= '0;
      inflight_q <= '0;
    end else begin
      bank_q     <= bank_d;
      count_q    <= count_d;
      addr_q     <= addr_d;
      sum_q      <= sum_d;
      inflight_q <= inflight_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/srec_back.sv
// Back end: turns queued commands into S3/S7 text, one character pair per step.
// Depends on srec_pkg and srec_if.
`default_nettype none

module srec_back
  import srec_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  cmd_t         head_i,
  input  wire          empty_i,
  output logic         pop_o,
  output buf_rd_t      rd_o,
  input  wire  [7:0]   rdata_i,
  output logic         data_done_o,
  srec_out_if.source   out_o
);

  phase_e            phase_q, phase_d;
  cmd_t              cmd_q, cmd_d;
  logic              is_end_q, is_end_d;
  logic [CountW-1:0] idx_q, idx_d;

  logic              out_valid_q, out_valid_d;
  logic [15:0]       pair_q, pair_d;
  logic [1:0]        pcnt_q, pcnt_d;
  logic              last_q, last_d;

  logic              adv;
  logic [CountW-1:0] cnt;
  logic [AddrW-1:0]  addr;
  logic [7:0]        dsum;
  logic [7:0]        chk;
  logic [7:0]        addr_byte;

  assign cnt  = is_end_q ? '0 : cmd_q.count;
  assign addr = is_end_q ? cmd_q.start_addr : cmd_q.rec_addr;
  assign dsum = is_end_q ? 8'd0 : cmd_q.sum;
  assign chk  = ~(cnt + CountBias + addr[31:24] + addr[23:16] + addr[15:8] + addr[7:0] + dsum);

  always_comb begin
    unique case (idx_q[1:0])
      2'd0:    addr_byte = addr[31:24];
      2'd1:    addr_byte = addr[23:16];
      2'd2:    addr_byte = addr[15:8];
      default: addr_byte = addr[7:0];
    endcase
  end

  assign adv = (phase_q != PhIdle) && (!out_valid_q || out_o.ready);

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    is_end_d    = is_end_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    data_done_o = 1'b0;
    pair_d      = pair_q;
    pcnt_d      = pcnt_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (phase_q == PhIdle) begin
      if (!empty_i) begin
        pop_o    = 1'b1;
        cmd_d    = head_i;
        is_end_d = !head_i.data_en;
        idx_d    = '0;
        phase_d  = PhHead;
      end
    end else if (adv) begin
      out_valid_d = 1'b1;
      pcnt_d      = 2'd2;
      last_d      = 1'b0;
      unique case (phase_q)
        PhHead: begin
          pair_d  = {CharS, is_end_q ? Char7 : Char3};
          phase_d = PhCount;
        end
        PhCount: begin
          pair_d  = hex_pair(cnt + CountBias);
          idx_d   = '0;
          phase_d = PhAddr;
        end
        PhAddr: begin
          pair_d = hex_pair(addr_byte);
          if (idx_q[1:0] == 2'd3) begin
            idx_d   = '0;
            phase_d = (cnt != '0) ? PhData : PhSum;
          end else begin
            idx_d = idx_q + CountW'(1);
          end
        end
        PhData: begin
          pair_d = hex_pair(rdata_i);
          if (idx_q + CountW'(1) == cnt) begin
            idx_d   = '0;
            phase_d = PhSum;
          end else begin
            idx_d = idx_q + CountW'(1);
          end
        end
        PhSum: begin
          pair_d  = hex_pair(chk);
          phase_d = PhEol;
        end
        PhEol: begin
          pair_d = {CharNl, 8'h00};
          pcnt_d = 2'd1;
          last_d = is_end_q || !cmd_q.end_en;
          if (!is_end_q && cmd_q.end_en) begin
            data_done_o = 1'b1;
            is_end_d    = 1'b1;
            phase_d     = PhHead;
          end else begin
            data_done_o = !is_end_q;
            phase_d     = PhIdle;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  // read address follows next-cycle index so data lines up with PhData
  assign rd_o = '{bank: cmd_d.bank, idx: idx_d};

  assign out_o.valid      = out_valid_q;
  assign out_o.char_pair  = pair_q;
  assign out_o.pair_count = pcnt_q;
  assign out_o.last       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      is_end_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      is_end_q    <= is_end_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pair_q <= pair_d;
    pcnt_q <= pcnt_d;
    last_q <= last_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/srecord_s3_emitter.sv
// Motorola S3 record emitter, top level.
// Depends on srec_pkg, srec_if, srec_front, srec_fifo, srec_buf, srec_back.
//
// in_i carries requests (data byte, set address, flush, end with start
// address); out_o carries the record text as character pairs, first
// character in bits 15..8, with last set on the final pair of a request.
// A full record of RECORD_BYTES bytes yields RECORD_BYTES + 8 pairs; the
// end record yields 8 pairs.
// The front takes one request per cycle and closes records into a
// two-entry command queue; the record bytes sit in a two-bank buffer, so
// the front fills one record while the back prints the other. Input is
// held off while both banks are in use or the queue is full.
// The back prints one pair per cycle while the receiver is ready and loads
// each command from the queue while idle, so sustained throughput is set by
// the output. The first pair of a record that a request closes passes the
// command queue, the back's command register and its output register.
// Reset empties the queue, clears the open record and sets the load
// address to zero. When the receiver stalls, the output pair is held and
// the back and then the front stop in turn.
`default_nettype none

module srecord_s3_emitter
  import srec_pkg::*;
#(
  parameter int unsigned RECORD_BYTES = 20
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  srec_in_if.sink    in_i,
  srec_out_if.source out_o
);

  cmd_t       push_cmd, head;
  logic       push, pop, full, empty, data_done;
  buf_wr_t    wr;
  buf_rd_t    rd;
  logic [7:0] rdata;

  srec_front #(.RECORD_BYTES(RECORD_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .fifo_full_i (full),
    .data_done_i (data_done),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .wr_o        (wr)
  );

  srec_fifo #(.DEPTH(2)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  srec_buf #(.RECORD_BYTES(RECORD_BYTES)) u_buf (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  srec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .rd_o        (rd),
    .rdata_i     (rdata),
    .data_done_o (data_done),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/srec_checker.sv
// Port-level checks for the S3 record emitter, bound to the top level.
// Depends on srec_pkg and srecord_s3_emitter.
`default_nettype none

module srec_checker
  import srec_pkg::*;
(
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [15:0] char_pair_i,
  input wire [1:0]  pair_count_i,
  input wire        last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_pair_i) && $stable(last_i))
    else $error("output request changed while stalled");

  a_single_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pair_count_i == 2'd1 |-> char_pair_i == {CharNl, 8'h00})
    else $error("single-character pair is not a newline");

  a_last_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> pair_count_i == 2'd1)
    else $error("last pair does not end a record");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pair_count_i == 2'd1 || pair_count_i == 2'd2)
    else $error("pair count out of range");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind srecord_s3_emitter srec_checker u_srec_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .char_pair_i  (out_o.char_pair),
  .pair_count_i (out_o.pair_count),
  .last_i       (out_o.last)
);

`default_nettype wire

>>> dv/srecord_s3_emitter_tb.sv
// Self-checking testbench for srecord_s3_emitter: directed and random requests with a
// predictor of the S3/S7 record text, checked pair by pair. Uses srec_pkg and srec_if.
`default_nettype none

module srecord_s3_emitter_tb
  import srec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RecordBytes = 20;
  localparam string HexDigits = "0123456789ABCDEF";

  typedef struct {
    op_e         op;
    logic [7:0]  data;
    logic [31:0] addr;
  } req_t;

  typedef struct {
    logic [15:0] chars;
    logic [1:0]  count;
    logic        last;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  srec_in_if  in_bus ();
  srec_out_if out_bus ();

  srecord_s3_emitter #(.RECORD_BYTES(RecordBytes)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // open record shadow
  logic [7:0]  open_bytes [RecordBytes];
  int unsigned open_len;
  logic [31:0] open_addr;
  logic [7:0]  open_sum;

  logic [7:0] line_chars [$];
  pair_t      item_pairs [$];
  pair_t      expected_pairs [$];
  req_t       req_backlog [$];

  req_t  live_req;
  pair_t want_pair;
  int    n_total, n_sent, n_got, err_count;
  int    n_full, n_partial, n_end;
  int    idle_left, stall_left, hold_left;
  bit    held_once;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void put_hex(input logic [7:0] b);
    line_chars.push_back(HexDigits[b[7:4]]);
    line_chars.push_back(HexDigits[b[3:0]]);
  endfunction

  function automatic void put_addr(input logic [31:0] a);
    put_hex(a[31:24]);
    put_hex(a[23:16]);
    put_hex(a[15:8]);
    put_hex(a[7:0]);
  endfunction

  // every line starts a fresh pair; odd tail goes out alone
  function automatic void send_line();
    for (int i = 0; i < line_chars.size(); i += 2) begin
      pair_t p;
      p.last = 1'b0;
      if (i + 1 < line_chars.size()) begin
        p.chars = {line_chars[i], line_chars[i + 1]};
        p.count = 2'd2;
      end else begin
        p.chars = {line_chars[i], 8'h00};
        p.count = 2'd1;
      end
      item_pairs.push_back(p);
    end
    line_chars.delete();
  endfunction

  function automatic void close_record();
    logic [7:0] count;
    logic [7:0] sum;
    if (open_len == 0) return;
    count = 8'(open_len) + CountBias;
    sum = count + open_addr[31:24] + open_addr[23:16] + open_addr[15:8] + open_addr[7:0]
          + open_sum;
    line_chars.push_back(CharS);
    line_chars.push_back(Char3);
    put_hex(count);
    put_addr(open_addr);
    for (int i = 0; i < open_len; i++) put_hex(open_bytes[i]);
    put_hex(~sum);
    line_chars.push_back(CharNl);
    send_line();
    if (open_len == RecordBytes) n_full++;
    else n_partial++;
    open_addr = open_addr + 32'(open_len);
    open_len  = 0;
    open_sum  = 8'h00;
  endfunction

  function automatic void start_record(input logic [31:0] a);
    open_addr = a;
    open_len  = 0;
    open_sum  = 8'h00;
  endfunction

  function automatic void predict_request(input req_t r);
    logic [7:0] sum;
    item_pairs.delete();
    case (r.op)
      OpData: begin
        open_bytes[open_len] = r.data;
        open_len++;
        open_sum = open_sum + r.data;
        if (open_len >= RecordBytes) close_record();
      end
      OpSetAddr: begin
        close_record();
        start_record(r.addr);
      end
      OpFlush: begin
        close_record();
      end
      default: begin
        close_record();
        sum = CountBias + r.addr[31:24] + r.addr[23:16] + r.addr[15:8] + r.addr[7:0];
        line_chars.push_back(CharS);
        line_chars.push_back(Char7);
        put_hex(CountBias);
        put_addr(r.addr);
        put_hex(~sum);
        line_chars.push_back(CharNl);
        send_line();
        n_end++;
        start_record(r.addr);
      end
    endcase
    if (item_pairs.size() > 0) item_pairs[item_pairs.size() - 1].last = 1'b1;
    foreach (item_pairs[i]) expected_pairs.push_back(item_pairs[i]);
  endfunction

  task automatic add_req(input op_e op, input logic [7:0] data, input logic [31:0] addr);
    req_t r;
    r.op   = op;
    r.data = data;
    r.addr = addr;
    req_backlog.push_back(r);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_request(live_req);
        n_sent++;
        idle_left = (n_sent >= 100 && n_sent < 160) ? 0 : pick_gap();
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (idle_left > 0 || req_backlog.size() == 0) begin
          if (idle_left > 0) idle_left--;
          in_bus.valid <= 1'b0;
        end else begin
          live_req = req_backlog.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.opcode    <= live_req.op;
          in_bus.data_byte <= live_req.data;
          in_bus.address   <= live_req.addr;
        end
      end
    end
  end

  // pair monitor and ready control
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_got++;
        if (expected_pairs.size() == 0) begin
          $error("unexpected pair %h (count %0d, last %0b)", out_bus.char_pair,
                 out_bus.pair_count, out_bus.last);
          err_count++;
        end else begin
          want_pair = expected_pairs.pop_front();
          if (out_bus.char_pair !== want_pair.chars) begin
            $error("char_pair: expected %h, got %h", want_pair.chars, out_bus.char_pair);
            err_count++;
          end
          if (out_bus.pair_count !== want_pair.count) begin
            $error("pair_count: expected %0d, got %0d", want_pair.count, out_bus.pair_count);
            err_count++;
          end
          if (out_bus.last !== want_pair.last) begin
            $error("last: expected %0b, got %0b", want_pair.last, out_bus.last);
            err_count++;
          end
        end
        stall_left = (n_got >= 250 && n_got < 400) ? 0 : pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (!held_once && n_got >= 120) begin
        held_once = 1'b1;
        hold_left = 400;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    int run;
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.opcode    = OpData;
    in_bus.data_byte = 8'h00;
    in_bus.address   = 32'h0;
    out_bus.ready    = 1'b0;
    open_len  = 0;
    open_addr = 32'h0;
    open_sum  = 8'h00;

    // directed: empty flush, full record wrapping past 2^32, partials, set to zero, ends
    add_req(OpFlush, 8'hFF, 32'hFFFF_FFFF);
    add_req(OpSetAddr, 8'h00, 32'hFFFF_FFF8);
    add_req(OpData, 8'h00, 32'h0);
    add_req(OpData, 8'hFF, 32'hFFFF_FFFF);
    add_req(OpData, 8'h80, 32'h0);
    add_req(OpData, 8'h7F, 32'h0);
    for (int i = 0; i < RecordBytes - 4; i++) add_req(OpData, 8'($urandom_range(0, 255)), $urandom);
    add_req(OpData, 8'h5A, 32'h0);
    add_req(OpSetAddr, 8'h00, 32'h0000_0000);
    add_req(OpData, 8'hA5, 32'h0);
    add_req(OpFlush, 8'h00, 32'h0);
    add_req(OpEnd, 8'h00, 32'hFFFF_FFFF);
    add_req(OpData, 8'h3C, 32'h0);
    add_req(OpEnd, 8'hFF, 32'h0000_0000);

    // random: runs of data bytes, mostly long enough to fill records, then a control request
    while (req_backlog.size() < 295) begin
      case ($urandom_range(0, 9))
        0:                run = 0;
        1, 2, 3:          run = $urandom_range(1, RecordBytes - 1);
        default:          run = $urandom_range(RecordBytes, 2 * RecordBytes + 5);
      endcase
      for (int i = 0; i < run; i++) add_req(OpData, 8'($urandom_range(0, 255)), $urandom);
      case ($urandom_range(0, 2))
        0:       add_req(OpSetAddr, 8'($urandom_range(0, 255)), pick_addr());
        1:       add_req(OpFlush, 8'($urandom_range(0, 255)), $urandom);
        default: add_req(OpEnd, 8'($urandom_range(0, 255)), pick_addr());
      endcase
    end
    n_total = req_backlog.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_sent == n_total);
    wait (expected_pairs.size() == 0);
    repeat (50) @(posedge clk_i);

    $display("Sent %0d requests; predicted %0d full, %0d partial and %0d end records.",
             n_total, n_full, n_partial, n_end);
    $display("Checked %0d character pairs, including one long output stall.", n_got);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
